// ===== src/sbde_pkg.sv =====
// Shared types and constants of the subsampled brightness depth easing block.
// No dependencies; every other file imports this package.
package sbde_pkg;

	// Default parameter values.
	localparam int VERTEX_DEPTH_DEF    = 1024;
	localparam int DEPTH_FRAC_BITS_DEF = 4;

	// Fixed widths.
	localparam int POS_W      = 10; // column, row, sampled column and row
	localparam int PHASE_W    = 6;  // position modulo the step (step is at most 64)
	localparam int DIM_W      = 11; // frame width and height
	localparam int STEP_W     = 7;
	localparam int WT_W       = 9;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 10; // red + green + blue
	localparam int PROD_W     = 21; // sampled row times columns per row plus column
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ENABLE = 3'd4;

	// Register reset values.
	localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST   = 11'd320;
	localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST  = 11'd240;
	localparam logic [STEP_W-1:0] SAMPLE_STEP_RST   = 7'd10;
	localparam logic [WT_W-1:0]   NEW_WEIGHT_RST    = 9'd102;
	localparam logic              MIRROR_ENABLE_RST = 1'b1;

	// Clamped configuration as the datapath sees it.
	typedef struct packed {
		logic [DIM_W-1:0]  width;   // 1 .. 1024
		logic [DIM_W-1:0]  height;  // 1 .. 1024
		logic [STEP_W-1:0] step;    // 1 .. 64
		logic [WT_W-1:0]   weight;  // 0 .. 256
		logic              mirror;
	} cfg_t;

	// One sampling decision handed from the position tracker to the easing pipe.
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] srow;
		logic [POS_W-1:0] scol;
		logic [DIM_W-1:0] cpr;     // sampled columns per row
	} sample_t;

	// Status of the easing pipe toward the top level.
	typedef struct packed {
		logic advance;   // pipeline moves this cycle
		logic clearing;  // depth memory clearing pass is running
	} ease_stat_t;

endpackage

// ===== src/sbde_div.sv =====
// Restoring divider, one quotient bit per cycle, for position recomputation.
// Depends on sbde_pkg.
module sbde_div
	import sbde_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POS_W-1:0]   dividend,
	input  logic [STEP_W-1:0]  divisor,
	output logic               done,
	output logic [POS_W-1:0]   quot,
	output logic [STEP_W-1:0]  rem
);

	localparam int CNT_W = $clog2(POS_W);

	logic [STEP_W-1:0] rem_q;
	logic [POS_W-1:0]  quo_q;
	logic [STEP_W-1:0] div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;

	logic [STEP_W:0] trial;
	logic [STEP_W:0] diff;
	logic            ge;

	// The partial remainder stays below the divisor, so one more bit fits.
	assign trial = {rem_q, quo_q[POS_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(POS_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== src/sbde_pos.sv =====
// Raster position tracker: counters, sampling phases and the sampling decision.
// Depends on sbde_pkg and sbde_div.
module sbde_pos
	import sbde_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    recalc,
	input  logic    accept,
	input  logic    frame_start,
	output logic    busy,
	output sample_t smp
);

	// Recompute sequence: last column position, current row, current column.
	typedef enum logic [6:0] {
		SEQ_IDLE   = 7'b0000001,
		SEQ_LOAD_W = 7'b0000010,
		SEQ_RUN_W  = 7'b0000100,
		SEQ_LOAD_R = 7'b0001000,
		SEQ_RUN_R  = 7'b0010000,
		SEQ_LOAD_C = 7'b0100000,
		SEQ_RUN_C  = 7'b1000000
	} seq_t;

	seq_t seq_q;

	logic [POS_W-1:0]   cc_q, rc_q, scol_q, srow_q, qmax_q;
	logic [PHASE_W-1:0] cph_q, rph_q, rmax_q;

	logic [POS_W-1:0]   cc_cur, rc_cur, scol_cur, srow_cur, scol_start;
	logic [PHASE_W-1:0] cph_cur, rph_cur, cph_start;
	logic [DIM_W-1:0]   w_m1;
	logic [POS_W-1:0]   col_now;
	logic [STEP_W-1:0]  s_m1;
	logic [STEP_W-1:0]  cph_inc, rph_inc;
	logic               last_col, last_row;

	logic               div_start, div_done;
	logic [POS_W-1:0]   div_dividend, div_quot;
	logic [STEP_W-1:0]  div_rem;

	sbde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cfg.step),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign w_m1    = cfg.width - 1'b1;
	assign col_now = cfg.mirror ? (w_m1[POS_W-1:0] - cc_q) : cc_q;
	assign s_m1    = cfg.step - 1'b1;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = w_m1[POS_W-1:0];
		case (seq_q)
			SEQ_LOAD_W: begin
				div_start    = 1'b1;
				div_dividend = w_m1[POS_W-1:0];
			end
			SEQ_LOAD_R: begin
				div_start    = 1'b1;
				div_dividend = rc_q;
			end
			SEQ_LOAD_C: begin
				div_start    = 1'b1;
				div_dividend = col_now;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_LOAD_W;
		end else if (recalc) begin
			seq_q <= SEQ_LOAD_W;
		end else begin
			case (seq_q)
				SEQ_IDLE:   seq_q <= SEQ_IDLE;
				SEQ_LOAD_W: seq_q <= SEQ_RUN_W;
				SEQ_RUN_W:  if (div_done) seq_q <= SEQ_LOAD_R;
				SEQ_LOAD_R: seq_q <= SEQ_RUN_R;
				SEQ_RUN_R:  if (div_done) seq_q <= SEQ_LOAD_C;
				SEQ_LOAD_C: seq_q <= SEQ_RUN_C;
				SEQ_RUN_C:  if (div_done) seq_q <= SEQ_IDLE;
				default:    seq_q <= SEQ_LOAD_W;
			endcase
		end
	end

	assign busy = (seq_q != SEQ_IDLE);

	// A frame start puts this pixel at the origin before it is judged.
	assign cph_start  = cfg.mirror ? rmax_q : '0;
	assign scol_start = cfg.mirror ? qmax_q : '0;
	assign cc_cur     = frame_start ? '0 : cc_q;
	assign rc_cur     = frame_start ? '0 : rc_q;
	assign cph_cur    = frame_start ? cph_start : cph_q;
	assign scol_cur   = frame_start ? scol_start : scol_q;
	assign rph_cur    = frame_start ? '0 : rph_q;
	assign srow_cur   = frame_start ? '0 : srow_q;

	assign last_col = ({1'b0, cc_cur} + 1'b1) >= cfg.width;
	assign last_row = ({1'b0, rc_cur} + 1'b1) >= cfg.height;
	assign cph_inc  = {1'b0, cph_cur} + 1'b1;
	assign rph_inc  = {1'b0, rph_cur} + 1'b1;

	always_comb begin
		smp.valid = accept && ({1'b0, cc_cur} < cfg.width) && ({1'b0, rc_cur} < cfg.height)
			&& (cph_cur == '0) && (rph_cur == '0);
		smp.srow  = srow_cur;
		smp.scol  = scol_cur;
		smp.cpr   = {1'b0, qmax_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			rc_q   <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			scol_q <= '0;
			srow_q <= '0;
			qmax_q <= '0;
			rmax_q <= '0;
		end else if (busy) begin
			if (div_done && seq_q == SEQ_RUN_W) begin
				qmax_q <= div_quot;
				rmax_q <= div_rem[PHASE_W-1:0];
			end
			if (div_done && seq_q == SEQ_RUN_R) begin
				srow_q <= div_quot;
				rph_q  <= div_rem[PHASE_W-1:0];
			end
			if (div_done && seq_q == SEQ_RUN_C) begin
				scol_q <= div_quot;
				cph_q  <= div_rem[PHASE_W-1:0];
			end
		end else if (accept) begin
			if (last_col) begin
				cc_q   <= '0;
				cph_q  <= cph_start;
				scol_q <= scol_start;
				if (last_row) begin
					rc_q   <= '0;
					rph_q  <= '0;
					srow_q <= '0;
				end else begin
					rc_q <= rc_cur + 1'b1;
					if (rph_inc == cfg.step) begin
						rph_q  <= '0;
						srow_q <= srow_cur + 1'b1;
					end else begin
						rph_q  <= rph_inc[PHASE_W-1:0];
						srow_q <= srow_cur;
					end
				end
			end else begin
				cc_q   <= cc_cur + 1'b1;
				rc_q   <= rc_cur;
				rph_q  <= rph_cur;
				srow_q <= srow_cur;
				if (cfg.mirror) begin
					// Mirrored columns count down toward the left edge.
					if (cph_cur == '0) begin
						cph_q  <= s_m1[PHASE_W-1:0];
						scol_q <= scol_cur - 1'b1;
					end else begin
						cph_q  <= cph_cur - 1'b1;
						scol_q <= scol_cur;
					end
				end else begin
					if (cph_inc == cfg.step) begin
						cph_q  <= '0;
						scol_q <= scol_cur + 1'b1;
					end else begin
						cph_q  <= cph_inc[PHASE_W-1:0];
						scol_q <= scol_cur;
					end
				end
			end
		end
	end

endmodule

// ===== src/sbde_ease.sv =====
// Depth memory with read-modify-write easing pipeline, clearing pass and output word.
// Depends on sbde_pkg.
module sbde_ease
	import sbde_pkg::*;
#(
	parameter int VERTEX_DEPTH    = VERTEX_DEPTH_DEF,
	parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [WT_W-1:0]            weight,
	input  sample_t                    smp,
	input  logic [CH_W-1:0]            red,
	input  logic [CH_W-1:0]            green,
	input  logic [CH_W-1:0]            blue,
	input  logic                       out_stall,
	output ease_stat_t                 stat,
	output logic                       out_valid,
	output logic [POS_W-1:0]           vertex_index,
	output logic [DEPTH_FRAC_BITS+8:0] depth,
	output logic [CH_W-1:0]            out_red,
	output logic [CH_W-1:0]            out_green,
	output logic [CH_W-1:0]            out_blue
);

	localparam int DW = SUM_W + DEPTH_FRAC_BITS - 1;
	localparam int AW = $clog2(VERTEX_DEPTH);
	localparam int MW = DW + WT_W;

	logic [DW-1:0] depth_mem_q [VERTEX_DEPTH];

	logic          advance;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// Stage 1: index and weighted target.
	logic             v_s1;
	logic [POS_W-1:0] srow_s1, scol_s1;
	logic [DIM_W-1:0] cpr_s1;
	logic [CH_W-1:0]  r_s1, g_s1, b_s1;

	logic [PROD_W-1:0] idx_full;
	logic              in_range;
	logic [AW-1:0]     addr_s1;
	logic [SUM_W-1:0]  rgb_sum;
	logic [DW-1:0]     target;
	logic [MW-1:0]     tw;

	// Stage 2: memory data back, blend and write.
	logic             v_s2;
	logic [AW-1:0]    addr_s2;
	logic [POS_W-1:0] vidx_s2;
	logic [MW-1:0]    tw_s2;
	logic [CH_W-1:0]  r_s2, g_s2, b_s2;
	logic             fwd_s2;
	logic [DW-1:0]    fwd_val_s2;
	logic [DW-1:0]    rdata_s2;

	logic [DW-1:0]   old_depth;
	logic [WT_W-1:0] keep_wt;
	logic [MW-1:0]   old_prod;
	logic [MW:0]     blend;
	logic [DW-1:0]   new_depth;

	logic             out_valid_q;
	logic [POS_W-1:0] vidx_q;
	logic [DW-1:0]    depth_q;
	logic [CH_W-1:0]  r_q, g_q, b_q;

	assign advance       = !out_valid_q || !out_stall;
	assign stat.advance  = advance;
	assign stat.clearing = clr_q;

	// Clearing pass over the whole memory after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(VERTEX_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= smp.valid;
			v_s2        <= v_s1 && in_range;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			srow_s1 <= smp.srow;
			scol_s1 <= smp.scol;
			cpr_s1  <= smp.cpr;
			r_s1    <= red;
			g_s1    <= green;
			b_s1    <= blue;
		end
	end

	assign idx_full = ({{(PROD_W-POS_W){1'b0}}, srow_s1} * {{(PROD_W-DIM_W){1'b0}}, cpr_s1})
		+ {{(PROD_W-POS_W){1'b0}}, scol_s1};
	assign in_range = idx_full < PROD_W'(VERTEX_DEPTH);
	assign addr_s1  = idx_full[AW-1:0];
	assign rgb_sum  = {2'b00, r_s1} + {2'b00, g_s1} + {2'b00, b_s1};
	assign target   = DW'(rgb_sum) << (DEPTH_FRAC_BITS - 1);
	assign tw       = {{WT_W{1'b0}}, target} * {{DW{1'b0}}, weight};

	// The item ahead writes its entry at the same edge that this one reads,
	// so a match takes the new depth straight from the blend.
	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s2    <= addr_s1;
			vidx_s2    <= idx_full[POS_W-1:0];
			tw_s2      <= tw;
			r_s2       <= r_s1;
			g_s2       <= g_s1;
			b_s2       <= b_s1;
			fwd_s2     <= v_s2 && (addr_s2 == addr_s1);
			fwd_val_s2 <= new_depth;
			rdata_s2   <= depth_mem_q[addr_s1];
		end
	end

	assign old_depth = fwd_s2 ? fwd_val_s2 : rdata_s2;
	assign keep_wt   = 9'd256 - weight;
	assign old_prod  = {{WT_W{1'b0}}, old_depth} * {{DW{1'b0}}, keep_wt};
	assign blend     = {1'b0, old_prod} + {1'b0, tw_s2} + (MW+1)'(128);
	assign new_depth = blend[DW+7:8];

	always_ff @(posedge clk) begin
		if (clr_q) begin
			depth_mem_q[clr_addr_q] <= '0;
		end else if (advance && v_s2) begin
			depth_mem_q[addr_s2] <= new_depth;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vidx_q  <= vidx_s2;
			depth_q <= new_depth;
			r_q     <= r_s2;
			g_q     <= g_s2;
			b_q     <= b_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = vidx_q;
	assign depth        = depth_q;
	assign out_red      = r_q;
	assign out_green    = g_q;
	assign out_blue     = b_q;

endmodule

// ===== src/subsampled_brightness_depth_easing.sv =====
// Top level of the subsampled brightness depth easing block.
// Depends on sbde_pkg, sbde_pos and sbde_ease.
//
// Pixels enter in raster order on the input channel (in_valid, in_stall),
// one word per pixel: frame_start, red, green, blue. Every sample_step-th
// pixel in both directions is kept; its stored vertex depth is eased toward
// (red+green+blue)/2 and one result word (vertex_index, depth, color) leaves
// on the output channel (out_valid, out_stall). Other pixels give no word.
// The block takes one pixel per clock while in_stall is low. A result word
// passes through the stage 1, stage 2 and output registers on its way out.
// The rate is set by the depth memory, which serves one read and one write
// each cycle; a back-to-back hit on the same vertex is forwarded.
// After reset the depth memory is cleared one entry per cycle, and in_stall
// stays high meanwhile. Every configuration write (cfg_valid, cfg_ready,
// cfg_index, cfg_data) starts a recomputation of the sampling phases by a
// serial divider, which holds in_stall high. When the receiver stalls, the
// output word holds and the pipeline freezes; in_stall follows out_stall
// while the output register is full.
module subsampled_brightness_depth_easing
	import sbde_pkg::*;
#(
	parameter int VERTEX_DEPTH    = VERTEX_DEPTH_DEF,
	parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write channel.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	// Pixel input channel.
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       frame_start,
	input  logic [CH_W-1:0]            red,
	input  logic [CH_W-1:0]            green,
	input  logic [CH_W-1:0]            blue,
	// Vertex output channel.
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [POS_W-1:0]           vertex_index,
	output logic [DEPTH_FRAC_BITS+8:0] depth,
	output logic [CH_W-1:0]            out_red,
	output logic [CH_W-1:0]            out_green,
	output logic [CH_W-1:0]            out_blue
);

	logic [DIM_W-1:0]  frame_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	logic [STEP_W-1:0] sample_step_q;
	logic [WT_W-1:0]   new_weight_q;
	logic              mirror_enable_q;

	cfg_t       cfg;
	sample_t    smp;
	ease_stat_t ease_stat;
	logic       cfg_write;
	logic       pos_busy;
	logic       accept;

	// Always ready; the user must make writes only while idle; not enforced.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			sample_step_q   <= SAMPLE_STEP_RST;
			new_weight_q    <= NEW_WEIGHT_RST;
			mirror_enable_q <= MIRROR_ENABLE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[DIM_W-1:0];
				CFG_SAMPLE_STEP:   sample_step_q   <= cfg_data[STEP_W-1:0];
				CFG_NEW_WEIGHT:    new_weight_q    <= cfg_data[WT_W-1:0];
				CFG_MIRROR_ENABLE: mirror_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Out-of-range register values are clamped to the nearest legal one.
	always_comb begin
		if (frame_width_q == '0) begin
			cfg.width = 11'd1;
		end else if (frame_width_q > 11'd1024) begin
			cfg.width = 11'd1024;
		end else begin
			cfg.width = frame_width_q;
		end
		if (frame_height_q == '0) begin
			cfg.height = 11'd1;
		end else if (frame_height_q > 11'd1024) begin
			cfg.height = 11'd1024;
		end else begin
			cfg.height = frame_height_q;
		end
		if (sample_step_q == '0) begin
			cfg.step = 7'd1;
		end else if (sample_step_q > 7'd64) begin
			cfg.step = 7'd64;
		end else begin
			cfg.step = sample_step_q;
		end
		cfg.weight = (new_weight_q > 9'd256) ? 9'd256 : new_weight_q;
		cfg.mirror = mirror_enable_q;
	end

	assign in_stall = !ease_stat.advance || ease_stat.clearing || pos_busy;
	assign accept   = in_valid && !in_stall;

	sbde_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.recalc      (cfg_write),
		.accept      (accept),
		.frame_start (frame_start),
		.busy        (pos_busy),
		.smp         (smp)
	);

	sbde_ease #(
		.VERTEX_DEPTH    (VERTEX_DEPTH),
		.DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
	) u_ease (
		.clk          (clk),
		.arst_n       (arst_n),
		.weight       (cfg.weight),
		.smp          (smp),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_stall    (out_stall),
		.stat         (ease_stat),
		.out_valid    (out_valid),
		.vertex_index (vertex_index),
		.depth        (depth),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue)
	);

endmodule

// ===== src/sbde_checker.sv =====
// Port-level checker for the subsampled brightness depth easing block, with its bind.
// Depends on sbde_pkg and the top level.
module sbde_checker
	import sbde_pkg::*;
#(
	parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [POS_W-1:0]           vertex_index,
	input logic [DEPTH_FRAC_BITS+8:0] depth,
	input logic [CH_W-1:0]            out_red,
	input logic [CH_W-1:0]            out_green,
	input logic [CH_W-1:0]            out_blue
);

	localparam int DEPTH_MAX = 765 * (1 << (DEPTH_FRAC_BITS - 1));

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vertex_index) && $stable(depth)
			&& $stable(out_red) && $stable(out_green) && $stable(out_blue))
		else $error("result word changed while stalled");

	// An eased depth never exceeds the largest target depth.
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(depth) <= DEPTH_MAX))
		else $error("depth above largest target");

	// After a register write the pixel input holds off while phases are recomputed.
	a_cfg_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("pixel taken right after a register write");

endmodule

bind subsampled_brightness_depth_easing sbde_checker #(
	.DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
) u_sbde_checker (.*);

// ===== dv/tb_subsampled_brightness_depth_easing.sv =====
// Self-checking testbench for subsampled_brightness_depth_easing: raster pixel words in,
// eased vertex depth words out, compared with an in-bench depth easing predictor.
// Depends on sbde_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_subsampled_brightness_depth_easing;
	import sbde_pkg::*;

	localparam int DEPTH_W        = DEPTH_FRAC_BITS_DEF + 9;
	// The output register sits behind stage 1 and stage 2; give it a little slack.
	localparam int SETTLE_CYCLES  = 8;
	// Longest legal quiet spell is the clearing pass after reset plus a divider
	// rerun and random gaps; take that several times over.
	localparam int WATCHDOG_LIMIT = 4 * VERTEX_DEPTH_DEF + 1000;
	// Pixel words in the whole run, directed tests included.
	localparam int PIXEL_BUDGET   = 1950;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_t;

	// One vertex word as the block should emit it.
	typedef struct {
		logic [POS_W-1:0]   idx;
		logic [DEPTH_W-1:0] depth;
		logic [CH_W-1:0]    r;
		logic [CH_W-1:0]    g;
		logic [CH_W-1:0]    b;
	} vertex_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 frame_start = 1'b0;
	logic [CH_W-1:0]      red = '0;
	logic [CH_W-1:0]      green = '0;
	logic [CH_W-1:0]      blue = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [POS_W-1:0]     vertex_index;
	logic [DEPTH_W-1:0]   depth;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;

	subsampled_brightness_depth_easing dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_start  (frame_start),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.depth        (depth),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the register file, raw as written (clamping happens on use).
	logic [DIM_W-1:0]  set_width  = FRAME_WIDTH_RST;
	logic [DIM_W-1:0]  set_height = FRAME_HEIGHT_RST;
	logic [STEP_W-1:0] set_step   = SAMPLE_STEP_RST;
	logic [WT_W-1:0]   set_weight = NEW_WEIGHT_RST;
	logic              set_mirror = MIRROR_ENABLE_RST;

	// Shadow of the position counters and the per-vertex depth store.
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned vertex_depths[VERTEX_DEPTH_DEF];

	vertex_t pending_vertices[$];
	vertex_t due;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned pixels_sent      = 0;
	int unsigned vertices_checked = 0;
	int unsigned settings_loaded  = 0;
	int unsigned mismatches       = 0;

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Predicts what one accepted pixel does: moves the raster position and, when
	// the pixel lands on a sampling point inside the store, eases that vertex's
	// depth toward half the pixel's brightness and queues the vertex word.
	task automatic ease_pixel(input logic fs, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int unsigned w, h, s, wt, col, per_row, vid, target, acc;
		vertex_t v;
		w  = clamp_to(set_width, 1, 1024);
		h  = clamp_to(set_height, 1, 1024);
		s  = clamp_to(set_step, 1, 64);
		wt = clamp_to(set_weight, 0, 256);
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		// A position left outside the frame by a mid-frame resize is never kept.
		if (col_pos < w && row_pos < h) begin
			col = set_mirror ? (w - 1 - col_pos) : col_pos;
			per_row = (w + s - 1) / s;
			if (col % s == 0 && row_pos % s == 0) begin
				vid = (row_pos / s) * per_row + col / s;
				// Samples past the end of the store are dropped silently.
				if (vid < VERTEX_DEPTH_DEF) begin
					target = r;
					target = (target + g + b) << (DEPTH_FRAC_BITS_DEF - 1);
					acc = vertex_depths[vid] * (256 - wt) + target * wt + 128;
					vertex_depths[vid] = acc >> 8;
					v.idx   = POS_W'(vid);
					v.depth = DEPTH_W'(vertex_depths[vid]);
					v.r = r;
					v.g = g;
					v.b = b;
					pending_vertices.push_back(v);
				end
			end
		end
		// Raster advance; the frame wraps by itself when no frame_start comes.
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		col_pos &= 32'h3FF;
		row_pos &= 32'h3FF;
	endtask

	// Offers one pixel word, after a random idle spell, and holds it until taken.
	task automatic send_pixel(input logic fs, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		frame_start <= fs;
		red         <= r;
		green       <= g;
		blue        <= b;
		do
			@(posedge clk);
		while (in_stall);
		ease_pixel(fs, r, g, b);
		pixels_sent++;
	endtask

	// Waits until every predicted vertex word has come out and the pipe is empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all five registers back to back; valid stays up across the burst.
	task automatic load_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] wt,
			input logic m);
		logic [CFG_IDX_W-1:0]  regs[5];
		logic [CFG_DATA_W-1:0] vals[5];
		regs = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_SAMPLE_STEP, CFG_NEW_WEIGHT,
			CFG_MIRROR_ENABLE};
		vals = '{w, h, s, wt, {{(CFG_DATA_W-1){1'b0}}, m}};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (regs[i])
				CFG_FRAME_WIDTH:   set_width  = vals[i];
				CFG_FRAME_HEIGHT:  set_height = vals[i];
				CFG_SAMPLE_STEP:   set_step   = vals[i][STEP_W-1:0];
				CFG_NEW_WEIGHT:    set_weight = vals[i][WT_W-1:0];
				CFG_MIRROR_ENABLE: set_mirror = vals[i][0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic set_idle(input idle_mix_t mix);
		send_idle_pct  = (mix == IDLE_SENDER) ? 65 : (mix == IDLE_BOTH) ? 11 : 0;
		recv_stall_pct = (mix == IDLE_RECEIVER) ? 65 : (mix == IDLE_BOTH) ? 11 : 0;
	endtask

	// Color channel biased toward the rails so both ends show up often.
	function automatic logic [CH_W-1:0] random_channel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	// Frame size: mostly small so vertices come often, sometimes zero,
	// large or beyond the clamp.
	function automatic logic [DIM_W-1:0] random_dim();
		case ($urandom_range(9))
			0: return '0;
			1: return DIM_W'($urandom_range(1024, 25));
			2: return DIM_W'($urandom_range(2047, 1025));
			default: return DIM_W'($urandom_range(24, 1));
		endcase
	endfunction

	// Settings out of reset: 320x240, step 10, mirrored. With the image mirrored,
	// the tenth pixel of row 0 is column 310 and the first kept vertex (index 31).
	task automatic test_default_settings();
		for (int i = 0; i < 10; i++) begin
			if (i == 0 || i == 9)
				send_pixel(i == 0, 8'hFF, 8'hFF, 8'hFF);
			else
				send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
		end
		settle();
	endtask

	// Full and zero weight, the end-of-frame wrap without frame_start, and every
	// register above or below its legal range.
	task automatic test_weight_and_clamps();
		load_settings(2, 1, 1, 256, 1'b0);
		send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
		send_pixel(1'b0, 8'h80, 8'h40, 8'h20);  // wraps back to vertex 0
		settle();
		// Width 0 acts as 1, height 2047 as 1024, step 0 as 1, weight 511 as 256.
		load_settings(0, 2047, 0, 511, 1'b1);
		send_pixel(1'b1, 8'h55, 8'hAA, 8'h0F);
		send_pixel(1'b0, 8'hF0, 8'h01, 8'h7E);
		settle();
		// Width 2000 acts as 1024, step 127 as 64; zero weight keeps the old depth.
		load_settings(2000, 1, 127, 0, 1'b0);
		send_pixel(1'b1, 8'hFF, 8'h00, 8'hFF);
		settle();
		// Mirrored full-width row: the first pixel is the top vertex index.
		load_settings(1024, 1, 1, 102, 1'b1);
		send_pixel(1'b1, 8'hC3, 8'h3C, 8'h99);
		settle();
	endtask

	// Build up two rows on a one-pixel-wide frame, then widen the frame so the
	// row counter points beyond the depth store; those samples must be dropped.
	task automatic test_index_overflow();
		load_settings(1, 1024, 1, 102, 1'b0);
		send_pixel(1'b1, 8'h10, 8'h20, 8'h30);
		send_pixel(1'b0, 8'hEF, 8'hDF, 8'hCF);
		settle();
		load_settings(1024, 1024, 1, 102, 1'b0);
		send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		settle();
	endtask

	// Shrink the frame in mid-row: the column counter is then outside the frame,
	// the pixel is not kept and the counters move on to the next row.
	task automatic test_outside_frame();
		load_settings(16, 4, 2, 200, 1'b0);
		send_pixel(1'b1, 8'h01, 8'h02, 8'h04);
		send_pixel(1'b0, 8'h08, 8'h10, 8'h20);
		send_pixel(1'b0, 8'h40, 8'h80, 8'hFF);
		settle();
		load_settings(2, 4, 2, 200, 1'b0);
		send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		settle();
	endtask

	// Random settings per phase, each with frames of up to 256 random pixels; some
	// frames are cut short or lack frame_start, and a few stray frame_start
	// words land in mid-frame. The idle mix rotates from phase to phase. The
	// run stops once the total pixel count reaches the budget.
	task automatic test_random_frames(input int unsigned budget);
		int unsigned phase_no, quota, sent, frame_len, w, h;
		logic fs;
		phase_no = 0;
		while (pixels_sent < budget) begin
			set_idle(idle_mix_t'(phase_no % 4));
			load_settings(random_dim(), random_dim(),
				CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(127)
					: $urandom_range(4, 1)),
				CFG_DATA_W'(($urandom_range(7) == 0) ? ($urandom_range(2) == 0 ? 0 :
					$urandom_range(1) ? 256 : 511) : $urandom_range(511)),
				1'($urandom_range(1)));
			w = clamp_to(set_width, 1, 1024);
			h = clamp_to(set_height, 1, 1024);
			quota = $urandom_range(160, 80);
			sent = 0;
			while (sent < quota && pixels_sent < budget) begin
				frame_len = (w * h > 256) ? 256 : w * h;
				if ($urandom_range(9) == 0)
					frame_len = $urandom_range(frame_len, 1);
				for (int p = 0; p < frame_len && sent < quota && pixels_sent < budget; p++) begin
					fs = (p == 0) ? ($urandom_range(19) != 0) : ($urandom_range(99) == 0);
					send_pixel(fs, random_channel(), random_channel(), random_channel());
					sent++;
				end
			end
			settle();
			phase_no++;
		end
	endtask

	// Receiver back-pressure, redrawn every cycle from the current mix.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ERROR %s: expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Every vertex word taken by the receiver is matched against the oldest
	// prediction; a word with nothing pending is itself a failure.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t ERROR unexpected vertex word: expected none, actual index %0d",
					$time, vertex_index);
				mismatches++;
			end else begin
				due = pending_vertices.pop_front();
				check_field("vertex_index", due.idx, vertex_index);
				check_field("depth", due.depth, depth);
				check_field("out_red", due.r, out_red);
				check_field("out_green", due.g, out_green);
				check_field("out_blue", due.b, out_blue);
				vertices_checked++;
			end
		end
	end

	// Ends the run when no word moves on any channel for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t timeout: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		foreach (vertex_depths[i])
			vertex_depths[i] = 0;
		set_idle(IDLE_NONE);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_default_settings();
		test_weight_and_clamps();
		test_index_overflow();
		test_outside_frame();
		test_random_frames(PIXEL_BUDGET);
		set_idle(IDLE_NONE);
		settle();
		$display("%0d pixel words over %0d register settings, %0d vertex words checked,",
			pixels_sent, settings_loaded, vertices_checked);
		$display("with idle and stall mixes of none, sender, receiver and both.");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sbde_pkg.sv
src/sbde_div.sv
src/sbde_pos.sv
src/sbde_ease.sv
src/subsampled_brightness_depth_easing.sv
src/sbde_checker.sv
dv/tb_subsampled_brightness_depth_easing.sv
